// File: design/ddct_pkg.sv
// ----------------------------------------------------------------------------
// ddct_pkg: shared types and constants of the dual down-counter timer
// Command codes, register map, control bit positions and the structs that
// travel between the top level and the timer slices.
// ----------------------------------------------------------------------------
package ddct_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CTL_W    = 8;
  localparam int unsigned PRE_W    = 7;
  localparam int unsigned PEXP_W   = 3;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned IN_TUSER_W  = 2;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // Register words.
  localparam logic [ADDR_W-1:0] REG_ENABLE = 4'd0;
  localparam logic [ADDR_W-1:0] REG_STATUS = 4'd1;

  // Word offsets inside one timer's block of four words.
  localparam logic [1:0] SUB_CTL = 2'd0;
  localparam logic [1:0] SUB_IVL = 2'd1;
  localparam logic [1:0] SUB_CNT = 2'd2;

  // Control word bit positions.
  localparam int unsigned CTL_EN      = 0;
  localparam int unsigned CTL_LOAD    = 1;
  localparam int unsigned CTL_SRC_LO  = 2;
  localparam int unsigned CTL_PRE_LO  = 4;
  localparam int unsigned CTL_ONESHOT = 7;

  // Clock source select codes.
  localparam logic [1:0] SRC_SLOW = 2'd0;
  localparam logic [1:0] SRC_FAST = 2'd1;

  typedef struct packed {
    logic              tick;
    logic              fast;
    logic              slow;
    logic              wr_ctl;
    logic              wr_ivl;
    logic              wr_cnt;
    logic [DATA_W-1:0] wdata;
  } timer_op_t;

  typedef struct packed {
    logic [CTL_W-1:0] ctl;
    logic             expire;
  } timer_stat_t;

endpackage

// File: design/ddct_timer.sv
// ----------------------------------------------------------------------------
// ddct_timer: one reload down counter with prescaler
// Holds control, interval, current count and prescale count of a single
// timer and applies one bus write or one tick per cycle.
// ----------------------------------------------------------------------------
module ddct_timer #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ddct_pkg::timer_op_t      op_i,
  output ddct_pkg::timer_stat_t    stat_o,
  output logic [COUNT_WIDTH-1:0]   ivl_o,
  output logic [COUNT_WIDTH-1:0]   cnt_o
);
  import ddct_pkg::*;

  logic [CTL_W-1:0]       ctl_q, ctl_d;
  logic [COUNT_WIDTH-1:0] ivl_q, ivl_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [PRE_W-1:0]       pre_q, pre_d;
  logic                   edge_sel;
  logic [PRE_W:0]         top_full;
  logic [PRE_W-1:0]       top;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   expire;

  always_comb begin
    unique case (ctl_q[CTL_SRC_LO +: 2])
      SRC_SLOW: edge_sel = op_i.slow;
      SRC_FAST: edge_sel = op_i.fast;
      default:  edge_sel = 1'b0;
    endcase
  end

  assign top_full = ((PRE_W + 1)'(1) << ctl_q[CTL_PRE_LO +: PEXP_W]) - (PRE_W + 1)'(1);
  assign top      = top_full[PRE_W-1:0];
  assign cnt_dec  = (cnt_q != '0) ? cnt_q - COUNT_WIDTH'(1) : cnt_q;

  always_comb begin
    ctl_d  = ctl_q;
    ivl_d  = ivl_q;
    cnt_d  = cnt_q;
    pre_d  = pre_q;
    expire = 1'b0;
    if (op_i.tick) begin
      if (ctl_q[CTL_EN] && edge_sel) begin
        if (pre_q >= top) begin
          pre_d = '0;
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            expire = 1'b1;
            if (ctl_q[CTL_ONESHOT]) begin
              ctl_d[CTL_EN] = 1'b0;
            end else begin
              cnt_d = ivl_q;
            end
          end
        end else begin
          pre_d = pre_q + PRE_W'(1);
        end
      end
    end else if (op_i.wr_ctl) begin
      ctl_d           = op_i.wdata[CTL_W-1:0];
      ctl_d[CTL_LOAD] = 1'b0;
      if (op_i.wdata[CTL_LOAD]) begin
        cnt_d = ivl_q;
        pre_d = '0;
      end
    end else if (op_i.wr_ivl) begin
      ivl_d = op_i.wdata[COUNT_WIDTH-1:0];
    end else if (op_i.wr_cnt) begin
      cnt_d = op_i.wdata[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      ivl_q <= '0;
      cnt_q <= '0;
      pre_q <= '0;
    end else begin
      ctl_q <= ctl_d;
      ivl_q <= ivl_d;
      cnt_q <= cnt_d;
      pre_q <= pre_d;
    end
  end

  assign stat_o.ctl    = ctl_q;
  assign stat_o.expire = expire;
  assign ivl_o         = ivl_q;
  assign cnt_o         = cnt_q;

endmodule

// File: design/dual_down_counter_timer.sv
// ----------------------------------------------------------------------------
// dual_down_counter_timer: two reload down counters behind word registers
// Streaming front end, interrupt enable and status registers, read mux and
// result register around a row of timer slices.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the consumer does not stall,
// and gives one result beat for each: a bus read, a bus write or a clock
// tick that carries edges of the fast and slow source clocks. A beat
// accepted at one edge sits in the input register, is applied to the
// timers and registers once the result register is free or being taken,
// and its result then stands in the output register; only the decrement,
// compare and select logic lies between those two registers. While the
// result register is held by a stalled consumer, one further beat is
// buffered in the input register before s_axis_tready_o drops. The
// interrupt line in each result is the OR of status AND enable, taken
// after the beat has been applied.
// ----------------------------------------------------------------------------
module dual_down_counter_timer #(
  parameter int unsigned NUM_TIMERS  = 2,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: [3:0] word_addr, [35:4] write_data, [36] fast_edge,
  //        [37] slow_edge, [39:38] zero
  input  logic [ddct_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // tuser: [1:0] cmd
  input  logic [ddct_pkg::IN_TUSER_W-1:0]      s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tdata: [31:0] read_data, [32] irq_line, [39:33] zero
  output logic [ddct_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import ddct_pkg::*;

  // Input register, loaded whenever it is empty or being drained.
  logic              in_valid_q;
  cmd_e              in_cmd_q;
  logic [ADDR_W-1:0] in_addr_q;
  logic [DATA_W-1:0] in_wdata_q;
  logic              in_fast_q;
  logic              in_slow_q;

  // Result register.
  logic              out_valid_q;
  logic [DATA_W-1:0] out_rdata_q;
  logic              out_irq_q;

  // Interrupt enable and write-1-to-clear status.
  logic [NUM_TIMERS-1:0] ena_q, ena_d;
  logic [NUM_TIMERS-1:0] pend_q, pend_d;

  logic                   process;
  logic                   is_read;
  logic                   is_write;
  logic                   is_tick;
  logic [DATA_W-1:0]      rdata;
  logic [NUM_TIMERS-1:0]  expire;
  logic [NUM_TIMERS-1:0]  hit;

  timer_op_t              op     [NUM_TIMERS];
  timer_stat_t            stat   [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] ivl_w  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cnt_w  [NUM_TIMERS];

  // A beat is worked on when the result register is free or being taken.
  assign process         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q   <= cmd_e'(s_axis_tuser_i[1:0]);
      in_addr_q  <= s_axis_tdata_i[3:0];
      in_wdata_q <= s_axis_tdata_i[35:4];
      in_fast_q  <= s_axis_tdata_i[36];
      in_slow_q  <= s_axis_tdata_i[37];
    end
  end

  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    is_tick  = 1'b0;
    unique case (in_cmd_q)
      CMD_READ:  is_read  = process;
      CMD_WRITE: is_write = process;
      CMD_TICK:  is_tick  = process;
      default: ;
    endcase
  end

  // Timer t owns words 4(t+1) to 4(t+1)+3.
  generate
    for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
      assign hit[t]       = (in_addr_q[3:2] == 2'(t + 1));
      assign op[t].tick   = is_tick;
      assign op[t].fast   = in_fast_q;
      assign op[t].slow   = in_slow_q;
      assign op[t].wr_ctl = is_write && hit[t] && (in_addr_q[1:0] == SUB_CTL);
      assign op[t].wr_ivl = is_write && hit[t] && (in_addr_q[1:0] == SUB_IVL);
      assign op[t].wr_cnt = is_write && hit[t] && (in_addr_q[1:0] == SUB_CNT);
      assign op[t].wdata  = in_wdata_q;

      ddct_timer #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_timer (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .op_i   (op[t]),
        .stat_o (stat[t]),
        .ivl_o  (ivl_w[t]),
        .cnt_o  (cnt_w[t])
      );

      assign expire[t] = stat[t].expire;
    end
  endgenerate

  // Enable and status updates; expiries arrive only on ticks, clears only
  // on writes, so the two never meet in one cycle.
  always_comb begin
    ena_d  = ena_q;
    pend_d = pend_q | expire;
    if (is_write && (in_addr_q == REG_ENABLE)) begin
      ena_d = in_wdata_q[NUM_TIMERS-1:0];
    end
    if (is_write && (in_addr_q == REG_STATUS)) begin
      pend_d = pend_q & ~in_wdata_q[NUM_TIMERS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ena_q  <= '0;
      pend_q <= '0;
    end else begin
      ena_q  <= ena_d;
      pend_q <= pend_d;
    end
  end

  // Read mux over the register words; unused words read as zero.
  always_comb begin
    rdata = '0;
    if (in_addr_q == REG_ENABLE) begin
      rdata = DATA_W'(ena_q);
    end else if (in_addr_q == REG_STATUS) begin
      rdata = DATA_W'(pend_q);
    end else begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        if (hit[t]) begin
          unique case (in_addr_q[1:0])
            SUB_CTL: rdata = DATA_W'(stat[t].ctl);
            SUB_IVL: rdata = DATA_W'(ivl_w[t]);
            SUB_CNT: rdata = DATA_W'(cnt_w[t]);
            default: rdata = '0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      out_rdata_q <= is_read ? rdata : '0;
      out_irq_q   <= |(pend_d & ena_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_irq_q, out_rdata_q};

`ifndef SYNTHESIS
  // A waiting result always reflects the interrupt state it left behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_irq_q == (|(pend_q & ena_q))))
    else $error("irq_line in result register disagrees with status and enable");

  // A timer expires only while a tick beat is being applied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|expire) |-> (process && (in_cmd_q == CMD_TICK)))
    else $error("timer expiry outside a tick beat");

  // Status bits are raised only by expiries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|(pend_d & ~pend_q)) |-> (|expire))
    else $error("status bit set without an expiry");

  // The input register is never overwritten while holding an unworked beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !process) |=> (in_valid_q && $stable(in_addr_q)
      && $stable(in_wdata_q)))
    else $error("buffered beat lost while the result register was stalled");
`endif

endmodule
